### src/mme_pkg.sv
package mme_pkg;

  localparam int DATA_W  = 32;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = CFG_IDX_W'(1);

  localparam logic [DATA_W-1:0] RESET_EXPONENT = 32'd6111579;
  localparam logic [DATA_W-1:0] RESET_MODULUS  = 32'd9173503;

  typedef logic [DATA_W-1:0] word_t;

  // request to the shared multiply-reduce unit
  typedef struct packed {
    logic  start;
    word_t op_a;
    word_t op_b;
  } mme_req_t;

  // response from the shared multiply-reduce unit
  typedef struct packed {
    logic  done;
    word_t result;
  } mme_rsp_t;

endpackage

### src/mme_mulred.sv
module mme_mulred
  import mme_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mme_req_t req,
  input  word_t    modulus,
  output mme_rsp_t rsp
);

  localparam int CNT_W = $clog2(PROD_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  word_t             rem_r, rem_nxt;

  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  word_t             rem_step;

  // restoring remainder: one product bit enters per cycle
  always_comb begin
    trial    = {rem_r, prod_r[PROD_W-1]};
    diff     = trial - {1'b0, modulus};
    rem_step = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    prod_nxt = prod_r;
    rem_nxt  = rem_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(PROD_W - 1);
      prod_nxt = PROD_W'(req.op_a) * PROD_W'(req.op_b);
      rem_nxt  = '0;
    end else if (busy_r) begin
      prod_nxt = {prod_r[PROD_W-2:0], 1'b0};
      rem_nxt  = rem_step;
      cnt_nxt  = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = rem_r;

endmodule

### src/modular_exponentiation_32_unit.sv
// modular exponentiation, 32 bits: out = base ^ exponent mod modulus
// in_* carries one base per item, out_* one power per item, in order.
// cfg_* writes the exponent (index 0) or the modulus (index 1, zero is
// stored as one); other indexes are ignored. write only while idle.
// each item runs on one shared multiply-reduce unit: a 32x32 multiply
// and then a 64-step restoring remainder per operation. an item costs
// one reduction of the base, a scan that skips the exponent's leading
// zeros, then one square per scanned bit and one more multiply per set
// bit. in_tready is high only while no item is in progress.
// the finished result sits in an output register; the next item may be
// taken while it waits, and a second result waits in the sequencer
// until out_tready frees the register. reset empties both channels,
// holds both readies low and loads exponent 6111579 and modulus 9173503.
module modular_exponentiation_32_unit
  import mme_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,   // [31:0] base
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [DATA_W-1:0]    out_tdata,  // [31:0] power
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int BIT_W = $clog2(DATA_W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       state_r, state_nxt;
  word_t            exp_r, exp_nxt;
  word_t            mod_r, mod_nxt;
  word_t            base_r, base_nxt;
  word_t            acc_r, acc_nxt;
  word_t            shift_r, shift_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             start_r, start_nxt;
  word_t            op_a_r, op_a_nxt;
  word_t            op_b_r, op_b_nxt;
  logic             out_valid_r, out_valid_nxt;
  word_t            out_data_r, out_data_nxt;

  mme_req_t req;
  mme_rsp_t rsp;

  assign req.start = start_r;
  assign req.op_a  = op_a_r;
  assign req.op_b  = op_b_r;

  mme_mulred u_mulred (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .modulus (mod_r),
    .rsp     (rsp)
  );

  assign in_tready  = rst_n && (state_r == S_IDLE);
  assign cfg_ready  = rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    mod_nxt       = mod_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    shift_nxt     = shift_r;
    bit_nxt       = bit_r;
    start_nxt     = 1'b0;
    op_a_nxt      = op_a_r;
    op_b_nxt      = op_b_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_EXPONENT: exp_nxt = cfg_data;
        REG_MODULUS:  mod_nxt = (cfg_data == '0) ? DATA_W'(1) : cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          // base mod m is computed as base * 1 mod m
          op_a_nxt  = in_tdata;
          op_b_nxt  = DATA_W'(1);
          start_nxt = 1'b1;
          shift_nxt = exp_r;
          bit_nxt   = BIT_W'(DATA_W - 1);
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        if (rsp.done) begin
          base_nxt  = rsp.result;
          acc_nxt   = DATA_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // skip leading zeros, stop at bit 0 for a zero exponent
        if (bit_r != '0 && !shift_r[DATA_W-1]) begin
          shift_nxt = {shift_r[DATA_W-2:0], 1'b0};
          bit_nxt   = bit_r - BIT_W'(1);
        end else begin
          op_a_nxt  = acc_r;
          op_b_nxt  = acc_r;
          start_nxt = 1'b1;
          state_nxt = S_SQ;
        end
      end
      S_SQ, S_MUL: begin
        if (rsp.done) begin
          acc_nxt = rsp.result;
          if (state_r == S_SQ && shift_r[DATA_W-1]) begin
            op_a_nxt  = rsp.result;
            op_b_nxt  = base_r;
            start_nxt = 1'b1;
            state_nxt = S_MUL;
          end else if (bit_r == '0) begin
            state_nxt = S_DONE;
          end else begin
            shift_nxt = {shift_r[DATA_W-2:0], 1'b0};
            bit_nxt   = bit_r - BIT_W'(1);
            op_a_nxt  = rsp.result;
            op_b_nxt  = rsp.result;
            start_nxt = 1'b1;
            state_nxt = S_SQ;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      exp_r       <= RESET_EXPONENT;
      mod_r       <= RESET_MODULUS;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      mod_r       <= mod_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    acc_r      <= acc_nxt;
    shift_r    <= shift_nxt;
    bit_r      <= bit_nxt;
    op_a_r     <= op_a_nxt;
    op_b_r     <= op_b_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### verif/modexp_checker.sv
`timescale 1ns / 1ps

module modexp_checker
  import mme_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [DATA_W-1:0]    in_tdata,   // [31:0] base
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [DATA_W-1:0]    out_tdata,  // [31:0] power
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data,
  output int                   n_fail,
  output int                   n_pending
);

  word_t exponent_q;
  word_t modulus_q;
  word_t power_fifo[$];
  word_t want_power;

  // left-to-right square and multiply, every product reduced in 64 bits
  function automatic word_t predict_power(input word_t base, input word_t expo,
                                          input word_t modu);
    logic [PROD_W-1:0] acc;
    logic [PROD_W-1:0] b;
    logic [PROD_W-1:0] m;
    int                top;
    m   = PROD_W'(modu);
    b   = PROD_W'(base) % m;
    acc = PROD_W'(1);
    top = DATA_W - 1;
    while (top > 0 && !expo[top]) top--;
    for (int k = top; k >= 0; k--) begin
      acc = (acc * acc) % m;
      if (expo[k]) acc = (acc * b) % m;
    end
    return acc[DATA_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] power mismatch: %s", $realtime, msg);
    n_fail++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      exponent_q <= RESET_EXPONENT;
      modulus_q  <= RESET_MODULUS;
      power_fifo.delete();
      n_pending  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (power_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected item, power %h", out_tdata));
        end else begin
          want_power = power_fifo.pop_front();
          if (out_tdata !== want_power)
            report_mismatch($sformatf("got %h, want %h", out_tdata, want_power));
        end
      end
      if (in_tvalid && in_tready)
        power_fifo.push_back(predict_power(in_tdata, exponent_q, modulus_q));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_EXPONENT: exponent_q <= cfg_data;
          REG_MODULUS:  modulus_q  <= (cfg_data == '0) ? word_t'(1) : cfg_data;
          default: ;
        endcase
      end
      n_pending <= power_fifo.size();
    end
  end

endmodule

### verif/tb_modular_exponentiation_32_unit.sv
`timescale 1ns / 1ps

module tb_modular_exponentiation_32_unit;
  import mme_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  localparam int RAND_PHASES    = 5;
  localparam int ITEMS_PER_PHASE = 28;
  localparam int HOLD_CYCLES    = 12000;
  localparam int DRAIN_CYCLES   = 5000;
  localparam int IDLE_LIMIT     = 60000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [DATA_W-1:0]    in_tdata = '0;     // [31:0] base
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [DATA_W-1:0]    out_tdata;         // [31:0] power
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  int n_fail;
  int n_pending;

  bit    hold_req = 1'b0;
  bit    sender_steady = 1'b0;
  word_t cur_modulus = RESET_MODULUS;

  modular_exponentiation_32_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  modexp_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .n_fail     (n_fail),
    .n_pending  (n_pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // valid only drops when a gap is drawn, so back-to-back items keep it high
  task automatic send_base(input word_t base);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= base;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t val,
                           input bit keep_valid);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (!keep_valid) cfg_valid <= 1'b0;
    if (idx == REG_MODULUS) cur_modulus = val;
  endtask

  // stop offering and wait until every power has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  // receiver: short random stalls, calm stretches, one long hold-off
  initial begin : drain_results
    int stall;
    int n_got;
    bit steady;
    bit held;
    n_got  = 0;
    steady = 1'b0;
    held   = 1'b0;
    forever begin
      if (hold_req && !held) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else begin
        stall = steady ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      n_got++;
      if (n_got % 16 == 0) steady = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb_modular_exponentiation_32_unit: FAIL");
    $finish;
  end

  initial begin : stimulus
    word_t expo;
    word_t modu;
    word_t base;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, base at and around the modulus
    send_base(32'h0000_0000);
    send_base(32'h0000_0001);
    send_base(32'hFFFF_FFFF);
    send_base(RESET_MODULUS);
    send_base(RESET_MODULUS - 1);
    settle();

    // zero exponent: a single square of one
    write_reg(REG_EXPONENT, 32'h0000_0000, 1'b1);
    write_reg(REG_MODULUS, 32'hFFFF_FFFF, 1'b0);
    send_base(32'h0000_0000);
    send_base(32'h0000_0005);
    send_base(32'hFFFF_FFFF);
    settle();

    // zero modulus saturates to one, so every power is zero
    write_reg(REG_EXPONENT, 32'hFFFF_FFFF, 1'b1);
    write_reg(REG_MODULUS, 32'h0000_0000, 1'b0);
    send_base(32'h1234_5678);
    send_base(32'hFFFF_FFFF);
    settle();

    // modulus one with zero exponent
    write_reg(REG_MODULUS, 32'h0000_0001, 1'b1);
    write_reg(REG_EXPONENT, 32'h0000_0000, 1'b0);
    send_base(32'h0000_0007);
    settle();

    // all-ones exponent and modulus: the longest scan
    write_reg(REG_EXPONENT, 32'hFFFF_FFFF, 1'b1);
    write_reg(REG_MODULUS, 32'hFFFF_FFFF, 1'b0);
    send_base(32'hFFFF_FFFE);
    send_base(32'h8000_0000);
    send_base(32'h0000_0002);
    settle();

    // writes to indexes past the register list must change nothing
    write_reg(REG_EXPONENT, 32'h0000_0001, 1'b1);
    write_reg(REG_MODULUS, 32'hFFFF_FFFB, 1'b1);
    write_reg(REG_SPARE_2, 32'h0000_0000, 1'b1);
    write_reg(REG_SPARE_3, 32'hA5A5_5A5A, 1'b0);
    send_base(32'hFFFF_FFFF);
    send_base(32'h0000_0003);
    settle();

    // lone top exponent bit, even modulus
    write_reg(REG_EXPONENT, 32'h8000_0000, 1'b1);
    write_reg(REG_MODULUS, 32'h0000_0002, 1'b0);
    send_base(32'h0000_0003);
    send_base(32'h0000_0004);
    settle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0:       expo = $urandom();
        1:       expo = $urandom_range(0, 255);
        2:       expo = 32'hFFFF_FFFF ^ (32'h1 << $urandom_range(0, 31));
        default: expo = $urandom() | 32'h8000_0000;
      endcase
      case ($urandom_range(0, 3))
        0:       modu = $urandom();
        1:       modu = $urandom_range(1, 1000);
        2:       modu = 32'hFFFF_FFFF - $urandom_range(0, 100);
        default: modu = $urandom() | 32'h8000_0000;
      endcase
      if (ph == RAND_PHASES - 1) expo = 32'h0000_0000;
      write_reg(REG_EXPONENT, expo, 1'b1);
      write_reg(REG_MODULUS, modu, 1'b0);
      sender_steady = ($urandom_range(0, 2) == 0);
      // receiver holds off while items keep coming, so the input stalls
      if (ph == 1) begin
        hold_req      = 1'b1;
        sender_steady = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ($urandom_range(0, 7))
          0:       base = 32'h0000_0000;
          1:       base = 32'h0000_0001;
          2:       base = cur_modulus - 1;
          3:       base = cur_modulus;
          4:       base = 32'hFFFF_FFFF;
          default: base = $urandom();
        endcase
        send_base(base);
      end
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0 && n_pending == 0)
      $display("tb_modular_exponentiation_32_unit: PASS");
    else
      $display("tb_modular_exponentiation_32_unit: FAIL");
    $finish;
  end

endmodule

### sim.f
src/mme_pkg.sv
src/mme_mulred.sv
src/modular_exponentiation_32_unit.sv
verif/modexp_checker.sv
verif/tb_modular_exponentiation_32_unit.sv
